// File: hdl/edge_preserving_bisection_update_defines.svh
// ----------------------------------------------------------------------------
// assertion macros for the bisection update block
// ----------------------------------------------------------------------------
`ifndef EDGE_PRESERVING_BISECTION_UPDATE_DEFINES_SVH
`define EDGE_PRESERVING_BISECTION_UPDATE_DEFINES_SVH

// condition holds in the same cycle
`define EPBU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("epbu assertion failed");

// condition holds in the next cycle
`define EPBU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("epbu assertion failed");

`endif

// File: hdl/epbu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epbu_pkg
// shared types and constants of the edge-preserving bisection update
// ----------------------------------------------------------------------------
package epbu_pkg;

    localparam int NB_COUNT      = 8;
    localparam int MAX_STEPS_DEF = 40;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int STEPS_W       = 7;
    localparam int REM_W         = 36;
    localparam int IDX_W         = 8;

    localparam logic [IDX_W-1:0] REG_DELTA_SCALE  = 8'd0;
    localparam logic [IDX_W-1:0] REG_REG_STRENGTH = 8'd1;

    localparam logic [DATA_W-1:0] DELTA_RESET  = 32'h0001_0000;
    localparam logic [DATA_W-1:0] LAMBDA_RESET = 32'h0001_0000;

    localparam logic [63:0] INV_SQRT2_Q32 = 64'h0000_0000_B504_F334;

    // diagonal neighbours: up-left, up-right, down-left, down-right
    localparam logic [NB_COUNT-1:0] DIAG_MASK = 8'b1010_0101;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QLOAD,
        ST_QDIV,
        ST_BRACKET,
        ST_EVAL_LOAD,
        ST_NB_LOAD,
        ST_NB_DIV,
        ST_NB_ACC,
        ST_F_MUL,
        ST_F_DECIDE,
        ST_MID
    } state_t;

    typedef struct packed {
        logic load;
        logic quot_mode;
    } div_req_t;

    // 1/sqrt2 rounded to nearest with frac fraction bits
    function automatic logic [63:0] diag_weight(input int frac);
        return (INV_SQRT2_Q32 + (64'd1 << (31 - frac))) >> (32 - frac);
    endfunction

endpackage

// File: hdl/epbu_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epbu_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module epbu_div #(
    parameter int  FRAC_BITS = epbu_pkg::FRAC_BITS_DEF,
    localparam int QW        = epbu_pkg::DATA_W + FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  epbu_pkg::div_req_t           req,
    input  logic [epbu_pkg::REM_W-1:0]   rem_init,
    input  logic [QW-1:0]                quo_init,
    input  logic [epbu_pkg::REM_W-1:0]   den,
    output logic [QW-1:0]                quo,
    output logic                         done
);

    localparam int CNT_W = $clog2(QW + 1);
    localparam int RW    = epbu_pkg::REM_W;

    logic [RW-1:0]    rem_reg;
    logic [RW-1:0]    rem_next;
    logic [QW-1:0]    quo_reg;
    logic [QW-1:0]    quo_next;
    logic [RW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             active_reg;
    logic             done_reg;
    logic [RW:0]      rem_shift;
    logic [RW:0]      trial;
    logic             fits;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[QW-1]};
        trial     = rem_shift - {1'b0, den_reg};
        fits      = !trial[RW];
        rem_next  = fits ? trial[RW-1:0] : rem_shift[RW-1:0];
        quo_next  = {quo_reg[QW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.load)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= req.quot_mode ? CNT_W'(QW) : CNT_W'(FRAC_BITS);
            end
            else if (active_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            rem_reg <= rem_init;
            quo_reg <= quo_init;
            den_reg <= den;
        end
        else if (active_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

// File: hdl/edge_preserving_bisection_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_preserving_bisection_update
// per-pixel root search of the edge-preserving update by bisection
// ----------------------------------------------------------------------------
// channel  | transfer when          | payload
// input    | start & !busy          | curvature, gradient, centre_value, nb_*
// result   | done (one cycle)       | pixel_update, alpha_zero, limit_reached, steps_taken
// config   | cfg_valid & cfg_ready  | cfg_index, cfg_data
//
// zero curvature: done in the cycle after the transfer, busy never rises
// otherwise busy from the cycle after the transfer through the quotient division, the
// bracket and n bisection steps; done rises as busy falls, and every neighbour
// term is formed by the shared one-bit-per-cycle divider
// rst_n clears the control state and loads the register reset values
// the receiver cannot stall; cfg_ready is always high
// ----------------------------------------------------------------------------
module edge_preserving_bisection_update #(
    parameter int MAX_STEPS = epbu_pkg::MAX_STEPS_DEF,
    parameter int FRAC_BITS = epbu_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic        [31:0]                 curvature,
    input  logic signed [31:0]                 gradient,
    input  logic signed [31:0]                 centre_value,
    input  logic signed [31:0]                 nb_up_left,
    input  logic signed [31:0]                 nb_up,
    input  logic signed [31:0]                 nb_up_right,
    input  logic signed [31:0]                 nb_left,
    input  logic signed [31:0]                 nb_right,
    input  logic signed [31:0]                 nb_down_left,
    input  logic signed [31:0]                 nb_down,
    input  logic signed [31:0]                 nb_down_right,
    output logic                               done,
    output logic signed [31:0]                 pixel_update,
    output logic                               alpha_zero,
    output logic                               limit_reached,
    output logic        [epbu_pkg::STEPS_W-1:0] steps_taken,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic        [epbu_pkg::IDX_W-1:0]  cfg_index,
    input  logic        [31:0]                 cfg_data
);

    localparam int NN    = epbu_pkg::NB_COUNT;
    localparam int QW    = epbu_pkg::DATA_W + FRAC_BITS;
    localparam int RW    = epbu_pkg::REM_W;
    localparam int SW    = epbu_pkg::STEPS_W;
    localparam int SUM_W = FRAC_BITS + 5;
    localparam int PR_W  = 33 + SUM_W;
    localparam int F_W   = 66;
    localparam int V_W   = 33;
    localparam int T_W   = 34;
    localparam logic [FRAC_BITS-1:0] W_DIAG =
        FRAC_BITS'(epbu_pkg::diag_weight(FRAC_BITS));
    localparam logic [SW-1:0] STEP_LIMIT = SW'(MAX_STEPS);
    localparam logic [64:0] PROD_LIMIT = 65'd1 << 61;
    localparam logic signed [QW:0] Q_MAX = (QW+1)'(64'sd2147483647);
    localparam logic signed [QW:0] Q_MIN = (QW+1)'(-64'sd2147483648);
    localparam logic signed [V_W-1:0] V_MAX = V_W'(64'sd2147483647);
    localparam logic signed [V_W-1:0] V_MIN = V_W'(-64'sd2147483648);

    epbu_pkg::state_t state_reg;
    epbu_pkg::state_t state_next;
    epbu_pkg::div_req_t div_req;

    logic [31:0]              delta_reg;
    logic [31:0]              lambda_reg;
    logic [31:0]              alpha_reg;
    logic signed [31:0]       beta_reg;
    logic signed [V_W-1:0]    diff_reg [NN];
    logic signed [V_W-1:0]    a_reg;
    logic signed [V_W-1:0]    b_reg;
    logic signed [V_W-1:0]    c_reg;
    logic signed [V_W-1:0]    x_reg;
    logic [2:0]               k_reg;
    logic [SW-1:0]            steps_reg;
    logic                     eval_a_reg;
    logic                     sign_a_reg;
    logic                     t_neg_reg;
    logic [64:0]              pmul_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [PR_W-1:0]   prod_reg;
    logic signed [63:0]       lin_reg;
    logic                     done_reg;
    logic signed [31:0]       pix_reg;
    logic                     az_reg;
    logic                     lim_reg;
    logic [SW-1:0]            st_reg;

    logic signed [31:0]       nb_in [NN];
    logic                     accept;
    logic [RW-1:0]            div_rem_init;
    logic [QW-1:0]            div_quo_init;
    logic [RW-1:0]            div_den;
    logic [QW-1:0]            div_quo;
    logic                     div_done;
    logic [31:0]              beta_mag;
    logic signed [QW:0]       q_s;
    logic signed [V_W-1:0]    q_clamp;
    logic signed [V_W-1:0]    d_cur;
    logic signed [V_W-1:0]    x_cur;
    logic [V_W-1:0]           x_mag;
    logic signed [T_W-1:0]    t_val;
    logic [T_W-1:0]           t_mag;
    logic [31:0]              dl;
    logic [FRAC_BITS-1:0]     g_val;
    logic [2*FRAC_BITS-1:0]   wg;
    logic [FRAC_BITS-1:0]     term;
    logic [61:0]              p_sat;
    logic signed [F_W-1:0]    f_val;
    logic                     f_zero;
    logic                     f_pos;
    logic signed [T_W-1:0]    width_ab;
    logic                     narrow;
    logic                     finish;
    logic signed [T_W-1:0]    ab_sum;

    assign nb_in[0] = nb_up_left;
    assign nb_in[1] = nb_up;
    assign nb_in[2] = nb_up_right;
    assign nb_in[3] = nb_left;
    assign nb_in[4] = nb_right;
    assign nb_in[5] = nb_down_left;
    assign nb_in[6] = nb_down;
    assign nb_in[7] = nb_down_right;

    assign accept    = start && (state_reg == epbu_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // datapath terms
    always_comb
    begin
        beta_mag = beta_reg[31] ? 32'(-{beta_reg[31], beta_reg}) : 32'(beta_reg);
        q_s = beta_reg[31] ? -signed'({1'b0, div_quo}) : signed'({1'b0, div_quo});
        if (q_s > Q_MAX)
            q_clamp = V_W'(Q_MAX);
        else if (q_s < Q_MIN)
            q_clamp = V_W'(Q_MIN);
        else
            q_clamp = V_W'(q_s);

        d_cur = diff_reg[k_reg];
        x_cur = eval_a_reg ? a_reg : c_reg;
        x_mag = x_cur[V_W-1] ? V_W'(-x_cur) : V_W'(x_cur);

        t_val = T_W'(x_reg) - T_W'(d_cur);
        t_mag = t_val[T_W-1] ? T_W'(-t_val) : T_W'(t_val);
        dl    = (delta_reg == 32'd0) ? 32'd1 : delta_reg;

        g_val = div_quo[FRAC_BITS-1:0];
        wg    = W_DIAG * g_val;
        term  = epbu_pkg::DIAG_MASK[k_reg] ? wg[2*FRAC_BITS-1:FRAC_BITS] : g_val;

        p_sat = (pmul_reg > PROD_LIMIT) ? PROD_LIMIT[61:0] : pmul_reg[61:0];

        // f in Q.2F: linear part, gradient part, penalty part
        f_val  = F_W'(lin_reg) - (F_W'(beta_reg) <<< (FRAC_BITS + 1)) + F_W'(prod_reg);
        f_zero = (f_val == '0);
        f_pos  = !f_val[F_W-1];

        width_ab = T_W'(b_reg) - T_W'(a_reg);
        narrow   = (width_ab < T_W'(2));
        finish   = !eval_a_reg && (f_zero || narrow || (steps_reg == STEP_LIMIT));
        ab_sum   = T_W'(a_reg) + T_W'(b_reg);

        if (state_reg == epbu_pkg::ST_QLOAD)
        begin
            div_rem_init = '0;
            div_quo_init = {beta_mag, {FRAC_BITS{1'b0}}};
            div_den      = RW'(alpha_reg);
        end
        else
        begin
            div_rem_init = RW'(t_mag);
            div_quo_init = '0;
            div_den      = RW'(dl) + RW'(t_mag);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            epbu_pkg::ST_IDLE:
                if (start && (curvature != 32'd0))
                    state_next = epbu_pkg::ST_QLOAD;
            epbu_pkg::ST_QLOAD:
                state_next = epbu_pkg::ST_QDIV;
            epbu_pkg::ST_QDIV:
                if (div_done)
                    state_next = epbu_pkg::ST_BRACKET;
            epbu_pkg::ST_BRACKET:
                if (k_reg == 3'd7)
                    state_next = epbu_pkg::ST_EVAL_LOAD;
            epbu_pkg::ST_EVAL_LOAD:
                state_next = epbu_pkg::ST_NB_LOAD;
            epbu_pkg::ST_NB_LOAD:
                state_next = epbu_pkg::ST_NB_DIV;
            epbu_pkg::ST_NB_DIV:
                if (div_done)
                    state_next = epbu_pkg::ST_NB_ACC;
            epbu_pkg::ST_NB_ACC:
                state_next = (k_reg == 3'd7) ? epbu_pkg::ST_F_MUL : epbu_pkg::ST_NB_LOAD;
            epbu_pkg::ST_F_MUL:
                state_next = epbu_pkg::ST_F_DECIDE;
            epbu_pkg::ST_F_DECIDE:
                state_next = finish ? epbu_pkg::ST_IDLE : epbu_pkg::ST_MID;
            epbu_pkg::ST_MID:
                state_next = epbu_pkg::ST_EVAL_LOAD;
            default:
                state_next = epbu_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        busy              = (state_reg != epbu_pkg::ST_IDLE);
        div_req.load      = (state_reg == epbu_pkg::ST_QLOAD) ||
                            (state_reg == epbu_pkg::ST_NB_LOAD);
        div_req.quot_mode = (state_reg == epbu_pkg::ST_QLOAD);
    end

    epbu_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .rem_init (div_rem_init),
        .quo_init (div_quo_init),
        .den      (div_den),
        .quo      (div_quo),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= epbu_pkg::ST_IDLE;
            done_reg   <= 1'b0;
            delta_reg  <= epbu_pkg::DELTA_RESET;
            lambda_reg <= epbu_pkg::LAMBDA_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (accept && (curvature == 32'd0)) ||
                         ((state_reg == epbu_pkg::ST_F_DECIDE) && finish);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == epbu_pkg::REG_DELTA_SCALE)
                    delta_reg <= cfg_data;
                else if (cfg_index == epbu_pkg::REG_REG_STRENGTH)
                    lambda_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            epbu_pkg::ST_IDLE:
                if (start)
                begin
                    alpha_reg  <= curvature;
                    beta_reg   <= gradient;
                    steps_reg  <= '0;
                    eval_a_reg <= 1'b1;
                    for (int i = 0; i < NN; i++)
                        diff_reg[i] <= V_W'(nb_in[i]) - V_W'(centre_value);
                    if (curvature == 32'd0)
                    begin
                        pix_reg <= '0;
                        az_reg  <= 1'b1;
                        lim_reg <= 1'b0;
                        st_reg  <= '0;
                    end
                end
            epbu_pkg::ST_QDIV:
                if (div_done)
                begin
                    a_reg <= q_clamp;
                    b_reg <= q_clamp;
                    k_reg <= '0;
                end
            epbu_pkg::ST_BRACKET:
            begin
                if (d_cur < a_reg)
                    a_reg <= d_cur;
                if (d_cur > b_reg)
                    b_reg <= d_cur;
                k_reg <= k_reg + 1'b1;
            end
            epbu_pkg::ST_EVAL_LOAD:
            begin
                x_reg    <= x_cur;
                pmul_reg <= 65'(alpha_reg) * 65'(x_mag);
                sum_reg  <= '0;
                k_reg    <= '0;
            end
            epbu_pkg::ST_NB_LOAD:
                t_neg_reg <= t_val[T_W-1];
            epbu_pkg::ST_NB_ACC:
            begin
                if (t_neg_reg)
                    sum_reg <= sum_reg - SUM_W'(term);
                else
                    sum_reg <= sum_reg + SUM_W'(term);
                k_reg <= k_reg + 1'b1;
            end
            epbu_pkg::ST_F_MUL:
            begin
                prod_reg <= PR_W'(signed'({1'b0, lambda_reg})) * PR_W'(sum_reg);
                lin_reg  <= x_reg[V_W-1] ? -(64'(p_sat) <<< 1) : (64'(p_sat) <<< 1);
            end
            epbu_pkg::ST_F_DECIDE:
            begin
                if (eval_a_reg)
                    sign_a_reg <= f_pos;
                else if (finish)
                begin
                    if (c_reg > V_MAX)
                        pix_reg <= 32'sh7FFF_FFFF;
                    else if (c_reg < V_MIN)
                        pix_reg <= 32'sh8000_0000;
                    else
                        pix_reg <= 32'(c_reg);
                    az_reg  <= 1'b0;
                    lim_reg <= !(f_zero || narrow);
                    st_reg  <= steps_reg;
                end
                else if (f_pos == sign_a_reg)
                    a_reg <= c_reg;
                else
                    b_reg <= c_reg;
            end
            epbu_pkg::ST_MID:
            begin
                c_reg      <= V_W'(ab_sum >>> 1);
                steps_reg  <= steps_reg + 1'b1;
                eval_a_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign done          = done_reg;
    assign pixel_update  = pix_reg;
    assign alpha_zero    = az_reg;
    assign limit_reached = lim_reg;
    assign steps_taken   = st_reg;

endmodule

// File: hdl/epbu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epbu_checker
// port-level checks of the bisection update block
// ----------------------------------------------------------------------------
`include "edge_preserving_bisection_update_defines.svh"

module epbu_checker #(
    parameter int MAX_STEPS = epbu_pkg::MAX_STEPS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [31:0]                   curvature,
    input logic                          done,
    input logic [31:0]                   pixel_update,
    input logic                          alpha_zero,
    input logic                          limit_reached,
    input logic [epbu_pkg::STEPS_W-1:0]  steps_taken
);

    localparam logic [epbu_pkg::STEPS_W-1:0] STEP_LIMIT = epbu_pkg::STEPS_W'(MAX_STEPS);

    `EPBU_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy)
    `EPBU_ASSERT_SAME(a_zero_result, clk, rst_n, done && alpha_zero,
        (pixel_update == 32'd0) && !limit_reached && (steps_taken == '0))
    `EPBU_ASSERT_SAME(a_limit_steps, clk, rst_n, done && limit_reached,
        steps_taken == STEP_LIMIT)
    `EPBU_ASSERT_SAME(a_search_steps, clk, rst_n, done && !alpha_zero,
        (steps_taken != '0) && (steps_taken <= STEP_LIMIT))
    `EPBU_ASSERT_NEXT(a_start_busy, clk, rst_n,
        start && !busy && (curvature != 32'd0), busy && !done)

endmodule

bind edge_preserving_bisection_update epbu_checker #(
    .MAX_STEPS (MAX_STEPS)
) u_epbu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .curvature     (curvature),
    .done          (done),
    .pixel_update  (pixel_update),
    .alpha_zero    (alpha_zero),
    .limit_reached (limit_reached),
    .steps_taken   (steps_taken)
);
